/* src/npc_pkg.sv */
// npc_pkg: shared types, constants and palette rom for the nearest palette color block
// no dependencies; used by npc_lane, npc_argmin and the top level
package npc_pkg;

  localparam int ROM_ROWS  = 18;
  localparam int ROM_COUNT = 5;
  localparam int DEF_NUM_ENTRIES = 18;

  // configuration register indexes
  localparam logic [1:0] CFG_PALETTE = 2'd0;
  localparam logic [1:0] CFG_MODE    = 2'd1;

  // distance modes
  localparam logic MODE_PLAIN   = 1'b0;
  localparam logic MODE_REDMEAN = 1'b1;

  localparam int SUM_W  = 20;  // widest weighted sum is below 2^20
  localparam int SQ_W   = 21;  // working width of the square root
  localparam int DIST_W = 10;  // floor of sqrt of a 20 bit value

  // reciprocal of 255 scaled by 2^34, exact for operands below 2^26
  localparam logic [26:0] RECIP_255 = 27'd67372037;

  // palette rom, rgb per row; rows 0..2 are the transparent keys
  localparam logic [23:0] PAL [ROM_COUNT][ROM_ROWS] = '{
    '{24'h000000, 24'hFF00FF, 24'h404040,
      24'h000000, 24'h23CB32, 24'h60DD6C, 24'h544EFF, 24'h7D70FF, 24'hD25442,
      24'h45E8FF, 24'hFA5948, 24'hFF7C6C, 24'hD3C63C, 24'hE5D26D, 24'h23B22C,
      24'hC85AC6, 24'hCCCCCC, 24'hFFFFFF},
    '{24'h000000, 24'hFF00FF, 24'h404040,
      24'h000000, 24'h24DA24, 24'h6DFF6D, 24'h2424FF, 24'h486DFF, 24'hB62424,
      24'h48DAFF, 24'hFF2424, 24'hFF6D6D, 24'hDADA24, 24'hDADA91, 24'h249124,
      24'hDA48B6, 24'hB6B6B6, 24'hFFFFFF},
    '{24'h000000, 24'hFF00FF, 24'h404040,
      24'h000000, 24'h66CC66, 24'h88EE88, 24'h4444DD, 24'h7777FF, 24'hBB5555,
      24'h77DDDD, 24'hDD6666, 24'hFF7777, 24'hCCCC55, 24'hEEEE88, 24'h55AA55,
      24'hBB55BB, 24'hCCCCCC, 24'hEEEEEE},
    '{24'h000000, 24'hFF00FF, 24'h404040,
      24'h000000, 24'h0AAD1E, 24'h34C84C, 24'h2B2DE3, 24'h514BFB, 24'hBD2925,
      24'h1EE2EF, 24'hFB2C2B, 24'hFF5F4C, 24'hBDA22B, 24'hD7B454, 24'h0A8C18,
      24'hAF329A, 24'hB2B2B2, 24'hFFFFFF},
    '{24'h000000, 24'hFF00FF, 24'h404040,
      24'h000000, 24'h3EB849, 24'h74D07D, 24'h5955E0, 24'h8076F1, 24'hB95E51,
      24'h65DBEF, 24'hDB6559, 24'hFF897D, 24'hCCC35E, 24'hDED087, 24'h3AA241,
      24'hB766B5, 24'hCCCCCC, 24'hFFFFFF}
  };

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] res;
  } sq_state_t;

  // rgb of one row; unused palette codes fall back to rom 0
  function automatic logic [23:0] rom_rgb(input logic [2:0] sel, input int row);
    logic [23:0] c;
    c = 24'h000000;
    if (row < ROM_ROWS) begin
      if (int'(sel) < ROM_COUNT) c = PAL[int'(sel)][row];
      else                       c = PAL[0][row];
    end
    return c;
  endfunction

  // index reported for a row: transparent keys give 0
  function automatic logic [3:0] row_index(input int row);
    logic [3:0] ix;
    ix = 4'd0;
    if (row >= 3) ix = 4'(row - 2);
    return ix;
  endfunction

  // one digit of the bitwise integer square root, bit = 4^k
  function automatic sq_state_t sq_step(input sq_state_t s, input int k);
    sq_state_t o;
    logic [SQ_W-1:0] bit_v;
    logic [SQ_W-1:0] trial;
    bit_v = SQ_W'(1) << (2 * k);
    trial = s.res + bit_v;
    if (s.v >= trial) begin
      o.v   = s.v - trial;
      o.res = (s.res >> 1) + bit_v;
    end else begin
      o.v   = s.v;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage

/* src/npc_pix_if.sv */
// npc_pix_if: valid/ready channel carrying one rgba pixel word
// no dependencies
interface npc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

/* src/npc_idx_if.sv */
// npc_idx_if: valid/ready channel carrying one palette index word
// no dependencies
interface npc_idx_if;
  logic       valid;
  logic       ready;
  logic [3:0] color_index;

  modport source (output valid, color_index, input ready);
  modport sink   (input valid, color_index, output ready);
endinterface

/* src/npc_lane.sv */
// npc_lane: six stage distance pipeline from one pixel to one palette row
// depends on npc_pkg
module npc_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        mode,
  input  logic [7:0]                  pix_r,
  input  logic [7:0]                  pix_g,
  input  logic [7:0]                  pix_b,
  input  logic [23:0]                 ent_rgb,
  output logic [npc_pkg::DIST_W-1:0]  row_dist
);

  logic [7:0]  dr, dg, db;
  logic [8:0]  sr;
  logic [15:0] dr2_r, dg2_r, db2_r;
  logic [10:0] wr_r, wb_r;
  logic [26:0] pr_r, pb_r;
  logic [17:0] g4_r, plain_r;
  logic [52:0] mr, mb;
  logic [17:0] qr_r, qb_r, g4b_r, plainb_r;
  logic [npc_pkg::SUM_W-1:0] sum_nxt, sum_r;
  npc_pkg::sq_state_t s5_nxt, s5_r, s6_nxt, s6_r;

  // stage 1: absolute differences and squares
  always_comb begin
    dr = (ent_rgb[23:16] > pix_r) ? ent_rgb[23:16] - pix_r : pix_r - ent_rgb[23:16];
    dg = (ent_rgb[15:8]  > pix_g) ? ent_rgb[15:8]  - pix_g : pix_g - ent_rgb[15:8];
    db = (ent_rgb[7:0]   > pix_b) ? ent_rgb[7:0]   - pix_b : pix_b - ent_rgb[7:0];
    sr = {1'b0, ent_rgb[23:16]} + {1'b0, pix_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr2_r <= dr * dr;
      dg2_r <= dg * dg;
      db2_r <= db * db;
      wr_r  <= 11'd1020 + {2'b0, sr};
      wb_r  <= 11'd1530 - {2'b0, sr};
    end
  end

  // stage 2: weighted products and plain sum
  always_ff @(posedge clk) begin
    if (en) begin
      pr_r    <= dr2_r * wr_r;
      pb_r    <= db2_r * wb_r;
      g4_r    <= {dg2_r, 2'b00};
      plain_r <= {2'b0, dr2_r} + {2'b0, dg2_r} + {2'b0, db2_r};
    end
  end

  // stage 3: divide by 510 as halve then reciprocal multiply by 1/255
  always_comb begin
    mr = pr_r[26:1] * npc_pkg::RECIP_255;
    mb = pb_r[26:1] * npc_pkg::RECIP_255;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr_r     <= mr[51:34];
      qb_r     <= mb[51:34];
      g4b_r    <= g4_r;
      plainb_r <= plain_r;
    end
  end

  // stage 4: pick the distance sum
  always_comb begin
    if (mode == npc_pkg::MODE_REDMEAN)
      sum_nxt = {2'b0, qr_r} + {2'b0, g4b_r} + {2'b0, qb_r};
    else
      sum_nxt = {2'b0, plainb_r};
  end

  always_ff @(posedge clk) begin
    if (en) sum_r <= sum_nxt;
  end

  // stages 5 and 6: square root, five digits each
  always_comb begin
    s5_nxt.v   = npc_pkg::SQ_W'(sum_r);
    s5_nxt.res = '0;
    for (int k = 9; k >= 5; k--) s5_nxt = npc_pkg::sq_step(s5_nxt, k);
    s6_nxt = s5_r;
    for (int k = 4; k >= 0; k--) s6_nxt = npc_pkg::sq_step(s6_nxt, k);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
    end
  end

  assign row_dist = s6_r.res[npc_pkg::DIST_W-1:0];

endmodule

/* src/npc_argmin.sv */
// npc_argmin: two stage registered minimum tree over the lane distances
// depends on npc_pkg
module npc_argmin #(
  parameter int LANES = npc_pkg::DEF_NUM_ENTRIES - 1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       az,
  input  logic                       out_vld,
  input  logic [npc_pkg::DIST_W-1:0] row_dist [LANES],
  output logic [3:0]                 idx
);

  localparam int LEAVES = 32;
  localparam int GROUPS = LEAVES / 4;

  typedef struct packed {
    logic [npc_pkg::DIST_W:0] d;
    logic [3:0]               ix;
  } cand_t;

  cand_t leaf [LEAVES];
  cand_t grp_nxt [GROUPS];
  cand_t grp_r [GROUPS];
  cand_t l1 [4];
  cand_t l2 [2];
  cand_t best;
  logic  az_r;
  logic [3:0] idx_nxt, idx_r;

  // earlier lane keeps the win on a tie
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.d < a.d) ? b : a;
  endfunction

  // leaves: real lanes, padding never wins
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < LANES) begin
        leaf[i].d  = {1'b0, row_dist[i]};
        leaf[i].ix = npc_pkg::row_index(i + 1);
      end else begin
        leaf[i].d  = '1;
        leaf[i].ix = 4'd0;
      end
    end
    for (int g = 0; g < GROUPS; g++)
      grp_nxt[g] = pick(pick(leaf[4*g], leaf[4*g+1]), pick(leaf[4*g+2], leaf[4*g+3]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
      az_r  <= az;
    end
  end

  // final three levels and transparent override
  always_comb begin
    for (int i = 0; i < 4; i++) l1[i] = pick(grp_r[2*i], grp_r[2*i+1]);
    for (int i = 0; i < 2; i++) l2[i] = pick(l1[2*i], l1[2*i+1]);
    best    = pick(l2[0], l2[1]);
    idx_nxt = az_r ? 4'd0 : best.ix;
  end

  always_ff @(posedge clk) begin
    if (en) idx_r <= idx_nxt;
  end

  assign idx = idx_r;

  // a stalled result word holds its index
  property p_hold;
    @(posedge clk) !en |=> $stable(idx_r);
  endproperty
  a_hold: assert property (p_hold) else $error("index changed during stall");

  // transparent pixel always maps to index zero
  property p_transp;
    @(posedge clk) (en && az_r) |=> (idx_r == 4'd0);
  endproperty
  a_transp: assert property (p_transp) else $error("transparent pixel not index 0");

  // a delivered index never points past the rom
  property p_range;
    @(posedge clk) out_vld |-> (idx_r <= 4'd15);
  endproperty
  a_range: assert property (p_range) else $error("index out of range");

endmodule

/* src/nearest_palette_color_index.sv */
// nearest_palette_color_index: top level, input stage, lanes, minimum tree and valid pipe
// depends on npc_pkg, npc_pix_if, npc_idx_if, npc_lane, npc_argmin
//
// Maps each rgba pixel word to the index of the nearest color of a built-in
// palette rom. in_ch takes one pixel word (red, green, blue, alpha) and out_ch
// gives one color_index word per pixel, in order. Alpha 0 yields index 0.
// cfg_we/cfg_index/cfg_wdata write palette_select (index 0) and
// distance_mode (index 1); write them only while the pipe is empty.
// An accepted word passes the input registers, the lane stages and the minimum tree to out_ch.
// Throughput: one word per cycle unless out_ch stalls; every lane row has its own distance unit, so
// the multipliers and square root stages each take a new pixel every clock.
// The pipe advances as a whole whenever the output register is empty or taken;
// when the receiver stalls the whole pipe holds and in_ch.ready drops.
// Reset (rst_n low, synchronous) empties the pipe and sets both registers to 0.
module nearest_palette_color_index #(
  parameter int NUM_ENTRIES = npc_pkg::DEF_NUM_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  npc_pix_if.sink    in_ch,
  npc_idx_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_wdata
);

  localparam int ROWS  = (NUM_ENTRIES < npc_pkg::ROM_ROWS) ? NUM_ENTRIES : npc_pkg::ROM_ROWS;
  localparam int LANES = ROWS - 1;
  localparam int DEPTH = 9;

  logic [2:0] pal_r;
  logic       mode_r;
  logic       en;
  logic [DEPTH-1:0] vld_r;
  logic [6:0] az_r;
  logic [7:0] pr_r, pg_r, pb_r;
  logic [npc_pkg::DIST_W-1:0] row_dist [LANES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r  <= 3'd0;
      mode_r <= npc_pkg::MODE_PLAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        npc_pkg::CFG_PALETTE: pal_r  <= cfg_wdata;
        npc_pkg::CFG_MODE:    mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // whole pipe advances when the output word is gone or absent
  assign en           = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[DEPTH-1];

  // valid bits and transparent flag travel with the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r <= in_ch.red;
      pg_r <= in_ch.green;
      pb_r <= in_ch.blue;
      az_r <= {az_r[5:0], (in_ch.alpha == 8'd0)};
    end
  end

  // one distance lane per rom row after row 0
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    npc_lane u_lane (
      .clk      (clk),
      .en       (en),
      .mode     (mode_r),
      .pix_r    (pr_r),
      .pix_g    (pg_r),
      .pix_b    (pb_r),
      .ent_rgb  (npc_pkg::rom_rgb(pal_r, i + 1)),
      .row_dist (row_dist[i])
    );
  end

  npc_argmin #(.LANES(LANES)) u_argmin (
    .clk      (clk),
    .en       (en),
    .az       (az_r[6]),
    .out_vld  (vld_r[DEPTH-1]),
    .row_dist (row_dist),
    .idx      (out_ch.color_index)
  );

  // stall freezes the valid pipe
  property p_vhold;
    @(posedge clk) disable iff (!rst_n) !en |=> $stable(vld_r);
  endproperty
  a_vhold: assert property (p_vhold) else $error("valid pipe moved during stall");

  // a word taken on input shows up in the first stage
  property p_enter;
    @(posedge clk) disable iff (!rst_n) (in_ch.valid && en) |=> vld_r[0];
  endproperty
  a_enter: assert property (p_enter) else $error("accepted word lost");

endmodule
